FILE: hw/rtl/multi_wheel_pid_with_command_timeout_macros.svh
// Assertion shorthands; clocked on clk, disabled while arst_n is low.
`ifndef MULTI_WHEEL_PID_WITH_COMMAND_TIMEOUT_MACROS_SVH
`define MULTI_WHEEL_PID_WITH_COMMAND_TIMEOUT_MACROS_SVH

// same-cycle implication
`define MW_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MW_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mwpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mwpid_pkg;

	localparam int MW_WHEEL_COUNT = 6;
	localparam int MW_VFB         = 8;

	localparam int CMD_W      = 2;
	localparam int WHEEL_W    = 3;
	localparam int VEL_W      = 16;
	localparam int INTEG_W    = 24;
	localparam int INTEG_FRAC = 8;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 8;
	localparam int LIMIT_W    = 16;
	localparam int TICK_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TDATA_W    = ((WHEEL_W + VEL_W + 7) / 8) * 8;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_TARGET   = 2'd0;
	localparam cmd_t CMD_MEASURED = 2'd1;
	localparam cmd_t CMD_TICK     = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_P_GAIN  = 3'd0;
	localparam cfg_idx_t CFG_I_GAIN  = 3'd1;
	localparam cfg_idx_t CFG_D_GAIN  = 3'd2;
	localparam cfg_idx_t CFG_UPPER   = 3'd3;
	localparam cfg_idx_t CFG_LOWER   = 3'd4;
	localparam cfg_idx_t CFG_TIMEOUT = 3'd5;

	localparam logic [GAIN_W-1:0]         RST_P_GAIN  = 16'd20480;
	localparam logic [GAIN_W-1:0]         RST_I_GAIN  = 16'd7680;
	localparam logic [GAIN_W-1:0]         RST_D_GAIN  = 16'd0;
	localparam logic signed [LIMIT_W-1:0] RST_UPPER   = 16'sd100;
	localparam logic signed [LIMIT_W-1:0] RST_LOWER   = -16'sd100;
	localparam logic [TICK_W-1:0]         RST_TIMEOUT = 8'd4;

	typedef struct packed {
		logic [GAIN_W-1:0]         p_gain;
		logic [GAIN_W-1:0]         i_gain;
		logic [GAIN_W-1:0]         d_gain;
		logic signed [LIMIT_W-1:0] upper;
		logic signed [LIMIT_W-1:0] lower;
		logic [TICK_W-1:0]         timeout;
	} cfg_t;

	// one memory entry per wheel
	typedef struct packed {
		logic signed [VEL_W-1:0]   target;
		logic signed [VEL_W-1:0]   measured;
		logic signed [VEL_W-1:0]   prev_meas;
		logic signed [INTEG_W-1:0] integ;
	} wheel_ent_t;

	localparam int ENT_W = $bits(wheel_ent_t);

endpackage
`default_nettype wire

FILE: hw/rtl/mwpid_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mwpid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mwpid_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module mwpid_cfg import mwpid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain  <= RST_P_GAIN;
			cfg_q.i_gain  <= RST_I_GAIN;
			cfg_q.d_gain  <= RST_D_GAIN;
			cfg_q.upper   <= RST_UPPER;
			cfg_q.lower   <= RST_LOWER;
			cfg_q.timeout <= RST_TIMEOUT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_P_GAIN:  cfg_q.p_gain  <= cfg_data;
				CFG_I_GAIN:  cfg_q.i_gain  <= cfg_data;
				CFG_D_GAIN:  cfg_q.d_gain  <= cfg_data;
				CFG_UPPER:   cfg_q.upper   <= cfg_data;
				CFG_LOWER:   cfg_q.lower   <= cfg_data;
				CFG_TIMEOUT: cfg_q.timeout <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mwpid_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Six-stage PID step for one wheel entry.
module mwpid_alu import mwpid_pkg::*; #(
	parameter int VFB = MW_VFB
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  wheel_ent_t              ent_in,
	input  cfg_t                    cfg,
	output logic                    done,
	output wheel_ent_t              ent_out,
	output logic signed [VEL_W-1:0] drive
);
	localparam int DIFF_W   = VEL_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int SUM_FRAC = GAIN_FRAC + VFB;
	localparam int SUM_W    = ((ACC_W > INTEG_W + VFB) ? ACC_W : INTEG_W + VFB) + 1;
	localparam logic signed [SUM_W-1:0] RND = (SUM_W'(1) <<< SUM_FRAC) - SUM_W'(1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	wheel_ent_t ent_s1, ent_s2, ent_s3, ent_s4, ent_s5, ent_s6;

	logic signed [DIFF_W-1:0]  err_s1, dm_s1;
	logic signed [PROD_W-1:0]  p_s2, i_s2, d_s2;
	logic signed [INTEG_W-1:0] ic_s3;
	logic signed [ACC_W-1:0]   pd_s3;
	logic signed [SUM_W-1:0]   sum_s4, cl_s5;
	logic signed [VEL_W-1:0]   drive_s6;

	logic signed [ACC_W-1:0]   integ_sum, integ_hi, integ_lo, integ_cl;
	logic signed [SUM_W-1:0]   sum_hi, sum_lo, sum_cl, sum_rnd;

	// integral update, clamped to the limits in Q.8
	always_comb begin
		integ_sum = ACC_W'(ent_s2.integ) + ACC_W'(i_s2 >>> VFB);
		integ_hi  = ACC_W'(cfg.upper) <<< INTEG_FRAC;
		integ_lo  = ACC_W'(cfg.lower) <<< INTEG_FRAC;
		if (integ_sum > integ_hi) begin
			integ_cl = integ_hi;
		end else if (integ_sum < integ_lo) begin
			integ_cl = integ_lo;
		end else begin
			integ_cl = integ_sum;
		end
	end

	always_comb begin
		sum_hi = SUM_W'(cfg.upper) <<< SUM_FRAC;
		sum_lo = SUM_W'(cfg.lower) <<< SUM_FRAC;
		if (sum_s4 > sum_hi) begin
			sum_cl = sum_hi;
		end else if (sum_s4 < sum_lo) begin
			sum_cl = sum_lo;
		end else begin
			sum_cl = sum_s4;
		end
	end

	// truncate toward zero: bias negatives before the arithmetic shift
	assign sum_rnd = (cl_s5 + (cl_s5[SUM_W-1] ? RND : '0)) >>> SUM_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= DIFF_W'(ent_in.target) - DIFF_W'(ent_in.measured);
		dm_s1  <= DIFF_W'(ent_in.measured) - DIFF_W'(ent_in.prev_meas);
		ent_s1 <= ent_in;

		p_s2   <= $signed({1'b0, cfg.p_gain}) * err_s1;
		i_s2   <= $signed({1'b0, cfg.i_gain}) * err_s1;
		d_s2   <= $signed({1'b0, cfg.d_gain}) * dm_s1;
		ent_s2 <= ent_s1;

		ic_s3  <= INTEG_W'(integ_cl);
		pd_s3  <= ACC_W'(p_s2) - ACC_W'(d_s2);
		ent_s3 <= '{target:    ent_s2.target,
		            measured:  ent_s2.measured,
		            prev_meas: ent_s2.measured,
		            integ:     INTEG_W'(integ_cl)};

		sum_s4 <= SUM_W'(pd_s3) + (SUM_W'(ic_s3) <<< VFB);
		ent_s4 <= ent_s3;

		cl_s5  <= sum_cl;
		ent_s5 <= ent_s4;

		drive_s6 <= sum_rnd[VEL_W-1:0];
		ent_s6   <= ent_s5;
	end

	assign done    = vld_s6;
	assign ent_out = ent_s6;
	assign drive   = drive_s6;

endmodule
`default_nettype wire

FILE: hw/rtl/multi_wheel_pid_with_command_timeout.sv
// Write items (target / measurement): read then write-back of the wheel entry.
// Tick item: per wheel, memory read, six-stage PID unit, emit, for each wheel in turn; after a
// timeout a zero-drive stop set follows, one item per wheel.
// One wheel entry in flight at a time; output back-pressure holds the emit and stop states.
// Reset (arst_n low, async): registers to defaults, tick count zero, all wheel entries read as
// zero through per-entry valid bits; no memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_wheel_pid_with_command_timeout_macros.svh"
module multi_wheel_pid_with_command_timeout import mwpid_pkg::*; #(
	parameter int WHEEL_COUNT            = MW_WHEEL_COUNT,
	parameter int VELOCITY_FRACTION_BITS = MW_VFB
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input item stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // [2:0] wheel_index, [18:3] velocity_value
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	// drive item stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // [2:0] wheel_number, [18:3] drive_value
	output logic [0:0]            m_tuser,   // [0] timeout_stop
	output logic                  m_tlast,   // last_of_set
	// register writes
	input  logic                  cfg_wr_en,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int WAW = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
	localparam logic [WAW-1:0] LAST_WHEEL = WAW'(WHEEL_COUNT - 1);
	localparam int PAD_W = TDATA_W - WHEEL_W - VEL_W;

	typedef enum logic [2:0] {
		ST_IDLE,     // ready for an item
		ST_WR_MOD,   // write item: entry read back, patch one field and store
		ST_TICK_MOD, // entry read back, launch PID unit
		ST_CALC,     // waiting on PID unit, store result entry
		ST_EMIT,     // hand drive to output register, fetch next wheel
		ST_STOP      // zero-drive set after timeout
	} state_t;

	state_t state_q;

	cfg_t cfg;

	// input unpack
	logic [WHEEL_W-1:0]      in_wheel;
	logic signed [VEL_W-1:0] in_vel;
	logic [WAW+WHEEL_W-1:0]  in_wheel_x;
	logic [WAW-1:0]          in_addr;
	logic                    accept, wheel_ok, wr_go, tick_go;

	// sequencer registers
	logic [WAW-1:0]          wheel_q;
	logic signed [VEL_W-1:0] vel_q;
	logic                    is_target_q;
	logic [TICK_W-1:0]       ticks_q;
	logic [WHEEL_COUNT-1:0]  valid_q;
	logic signed [VEL_W-1:0] drive_q;

	// output register
	logic                    m_tvalid_q;
	logic [WAW-1:0]          m_wheel_q;
	logic signed [VEL_W-1:0] m_drive_q;
	logic                    m_stop_q;
	logic                    m_last_q;
	logic [WAW+WHEEL_W-1:0]  m_wheel_x;

	logic                    out_free, out_load, last_wheel;
	logic [TICK_W-1:0]       ticks_inc;
	logic [WAW-1:0]          wheel_next;

	// memory ports
	logic                    rd_en, wr_en;
	logic [WAW-1:0]          rd_addr;
	logic [ENT_W-1:0]        rd_data, wr_data;
	wheel_ent_t              ent_rd, ent_mod;

	// PID unit
	logic                    alu_start, alu_done;
	wheel_ent_t              alu_ent;
	logic signed [VEL_W-1:0] alu_drive;

	mwpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// all wheel state: target, measurement, previous measurement, integral
	mwpid_ram #(
		.WIDTH (ENT_W),
		.DEPTH (WHEEL_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wheel_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mwpid_alu #(
		.VFB (VELOCITY_FRACTION_BITS)
	) u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (alu_start),
		.ent_in  (ent_rd),
		.cfg     (cfg),
		.done    (alu_done),
		.ent_out (alu_ent),
		.drive   (alu_drive)
	);

	assign in_wheel   = s_tdata[WHEEL_W-1:0];
	assign in_vel     = s_tdata[WHEEL_W+VEL_W-1:WHEEL_W];
	assign in_wheel_x = (WAW + WHEEL_W)'(in_wheel);
	assign in_addr    = in_wheel_x[WAW-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// wheels past the end are ignored, and so do not restart the timeout
	assign wheel_ok = 32'(in_wheel) < WHEEL_COUNT;
	assign wr_go    = ((s_tuser == CMD_TARGET) || (s_tuser == CMD_MEASURED)) && wheel_ok;
	// a zero timeout, or one lowered under the count, blocks every tick
	assign tick_go  = (s_tuser == CMD_TICK) && (ticks_q < cfg.timeout);

	assign out_free   = !m_tvalid_q || m_tready;
	// output register takes a new drive item this cycle
	assign out_load   = ((state_q == ST_EMIT) || (state_q == ST_STOP)) && out_free;
	assign last_wheel = (wheel_q == LAST_WHEEL);
	assign ticks_inc  = ticks_q + TICK_W'(1);
	assign wheel_next = wheel_q + WAW'(1);

	// entries never written read as zero
	assign ent_rd = valid_q[wheel_q] ? wheel_ent_t'(rd_data) : '0;

	always_comb begin
		ent_mod = ent_rd;
		if (is_target_q) begin
			ent_mod.target = vel_q;
		end else begin
			ent_mod.measured = vel_q;
		end
	end

	// Accesses never overlap on one entry: each write-back lands before the next read is issued.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = wheel_next;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept && (wr_go || tick_go);
				rd_addr = wr_go ? in_addr : '0;
			end
			ST_EMIT: begin
				rd_en   = out_free && !last_wheel;
				rd_addr = wheel_next;
			end
			default: ;
		endcase
	end

	assign wr_en     = (state_q == ST_WR_MOD) || ((state_q == ST_CALC) && alu_done);
	assign wr_data   = (state_q == ST_WR_MOD) ? ENT_W'(ent_mod) : ENT_W'(alu_ent);
	assign alu_start = (state_q == ST_TICK_MOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wheel_q     <= '0;
			vel_q       <= '0;
			is_target_q <= 1'b0;
			ticks_q     <= '0;
			valid_q     <= '0;
			drive_q     <= '0;
			m_tvalid_q  <= 1'b0;
			m_wheel_q   <= '0;
			m_drive_q   <= '0;
			m_stop_q    <= 1'b0;
			m_last_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (wr_go) begin
							wheel_q     <= in_addr;
							vel_q       <= in_vel;
							is_target_q <= (s_tuser == CMD_TARGET);
							if (s_tuser == CMD_TARGET) begin
								ticks_q <= '0;
							end
							state_q <= ST_WR_MOD;
						end else if (tick_go) begin
							wheel_q <= '0;
							state_q <= ST_TICK_MOD;
						end
					end
				end
				ST_WR_MOD: begin
					valid_q[wheel_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_TICK_MOD: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (alu_done) begin
						valid_q[wheel_q] <= 1'b1;
						drive_q          <= alu_drive;
						state_q          <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_wheel_q  <= wheel_q;
						m_drive_q  <= drive_q;
						m_stop_q   <= 1'b0;
						m_last_q   <= last_wheel;
						if (last_wheel) begin
							ticks_q <= ticks_inc;
							if (ticks_inc == cfg.timeout) begin
								wheel_q <= '0;
								state_q <= ST_STOP;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							wheel_q <= wheel_next;
							state_q <= ST_TICK_MOD;
						end
					end
				end
				ST_STOP: begin
					if (out_free) begin
						m_wheel_q  <= wheel_q;
						m_drive_q  <= '0;
						m_stop_q   <= 1'b1;
						m_last_q   <= last_wheel;
						if (last_wheel) begin
							state_q <= ST_IDLE;
						end else begin
							wheel_q <= wheel_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_wheel_x = (WAW + WHEEL_W)'(m_wheel_q);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {PAD_W'(0), m_drive_q, m_wheel_x[WHEEL_W-1:0]};
	assign m_tuser   = m_stop_q;
	assign m_tlast   = m_last_q;

	`MW_CHECK(a_alu_done_in_calc, alu_done, state_q == ST_CALC,
		"PID result arrived outside the wait state")
	`MW_CHECK_NEXT(a_calc_to_emit, (state_q == ST_CALC) && alu_done, state_q == ST_EMIT,
		"PID result not followed by emit")
	`MW_CHECK(a_wr_addr_range, wr_en, wheel_q <= LAST_WHEEL,
		"memory write beyond last wheel")
	`MW_CHECK(a_stop_zero_drive, m_tvalid && m_tuser[0], m_drive_q == '0,
		"stop item carries a nonzero drive")

endmodule
`default_nettype wire
